### rtl/core/bbc_pkg.sv
// Package for the bracket balance checker: command and status codes,
// character constants and shared defaults. No dependencies.
package bbc_pkg;

    // Default stack depth and the depth of the front-to-back queue
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH     = 2;

    // Bracket characters
    localparam logic [7:0] CHAR_LPAREN = 8'd40;
    localparam logic [7:0] CHAR_LBRACK = 8'd91;
    localparam logic [7:0] CHAR_LBRACE = 8'd123;
    localparam logic [7:0] CHAR_RPAREN = 8'd41;
    localparam logic [7:0] CHAR_RBRACK = 8'd93;
    localparam logic [7:0] CHAR_RBRACE = 8'd125;

    // Bracket type codes held on the stack
    localparam logic [1:0] TYPE_PAREN = 2'd1;
    localparam logic [1:0] TYPE_BRACK = 2'd2;
    localparam logic [1:0] TYPE_BRACE = 2'd3;
    localparam logic [1:0] TYPE_NONE  = 2'd0;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OPEN     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_kind_t;

    // One classified item as it travels through the queue
    typedef struct packed {
        op_kind_t   kind;
        logic [1:0] code;
        logic       last;
    } cmd_t;

    // Back-end activity, exported for checking
    typedef struct packed {
        logic exec;
        logic exec_last;
    } back_stat_t;

endpackage

### rtl/core/bracket_balance_checker.sv
// Bracket balance checker, top level.
// Input channel s_valid/s_ready carries one character per item with an
// end-of-string flag; output channel m_valid/m_ready carries one 2-bit
// status per string (0 ok, 1 mismatch or unopened closer, 2 left open,
// 3 overflow). An empty string is a single zero byte with the flag set.
// Throughput: one item per cycle while the status output is not stalled.
// The stack keeps its top in a register and prefetches the entry below it
// from the stack memory's registered read port, so pushes and pops follow
// each other every cycle. An accepted final item is first written into the
// queue, is executed when it leaves the queue, and its status is registered
// onto m_status. When the receiver stalls, the status holds; further
// characters keep flowing and only the next final item waits, then the
// two-entry queue fills and s_ready drops.
// Reset (aresetn low, synchronous) empties the queue, the stack and the
// error, and clears m_valid. The stack memory needs no clearing pass:
// only entries below the current depth are ever used.
// Depends on bbc_pkg, bbc_front, bbc_queue, bbc_back.
module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_byte,
    input  logic       s_end_of_string,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status
);

    cmd_t       front_cmd;
    cmd_t       q_cmd;
    logic       q_valid, q_ready;
    back_stat_t back_stat;

    // Classify incoming characters
    bbc_front u_front (
        .char_byte     (s_char_byte),
        .end_of_string (s_end_of_string),
        .cmd           (front_cmd)
    );

    // Decouple front and back
    bbc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (front_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    // Stack execution and status
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .stat      (back_stat)
    );

    // Queue is empty right after reset, so input is taken at once
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("s_ready low after reset");

    // A new status appears only after a final item was executed
    a_status_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid && !m_ready)) |-> $past(back_stat.exec_last))
        else $error("status posted without a final item");

    // The back end stalls only on a final item with the output blocked
    a_back_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !q_ready) |-> (q_cmd.last && m_valid && !m_ready))
        else $error("back end stalled without cause");

    // The back end executes exactly on a queue handshake
    a_exec_handshake: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.exec == (q_valid && q_ready))
        else $error("back end activity without a queue handshake");

endmodule

### rtl/core/bbc_front.sv
// Front end of the bracket balance checker: decodes a character into a
// stack command. Depends on bbc_pkg.
module bbc_front
    import bbc_pkg::*;
(
    input  logic [7:0] char_byte,
    input  logic       end_of_string,
    output cmd_t       cmd
);

    // Classify the byte as opener, closer or ignored
    always_comb begin
        cmd.last = end_of_string;
        cmd.kind = OP_NONE;
        cmd.code = TYPE_NONE;
        case (char_byte)
            CHAR_LPAREN: begin cmd.kind = OP_PUSH; cmd.code = TYPE_PAREN; end
            CHAR_LBRACK: begin cmd.kind = OP_PUSH; cmd.code = TYPE_BRACK; end
            CHAR_LBRACE: begin cmd.kind = OP_PUSH; cmd.code = TYPE_BRACE; end
            CHAR_RPAREN: begin cmd.kind = OP_POP;  cmd.code = TYPE_PAREN; end
            CHAR_RBRACK: begin cmd.kind = OP_POP;  cmd.code = TYPE_BRACK; end
            CHAR_RBRACE: begin cmd.kind = OP_POP;  cmd.code = TYPE_BRACE; end
            default: begin
                cmd.kind = OP_NONE;
                cmd.code = TYPE_NONE;
            end
        endcase
    end

endmodule

### rtl/core/bbc_queue.sv
// Short command queue between the front and back ends of the bracket
// balance checker. Depends on bbc_pkg.
module bbc_queue
    import bbc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/bbc_back.sv
// Back end of the bracket balance checker: bracket stack, sticky error and
// the status output register. Depends on bbc_pkg.
module bbc_back
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output back_stat_t stat
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

    // Stack storage: every entry written on push; top and next-under kept
    // in registers so a pop needs no read in the same cycle.
    logic [1:0]       stack_mem [STACK_DEPTH];
    logic [1:0]       top_reg, top_next;
    logic [1:0]       under_reg;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [1:0]       err_reg, err_next;
    logic             out_valid_reg;
    logic [1:0]       status_reg, status_next;
    logic             exec, push_en;
    logic [CNT_W-1:0] rd_cnt;
    logic [ADDR_W-1:0] rd_addr, wr_addr;

    // Stall only a final item whose status cannot be posted
    assign exec      = cmd_valid && (!cmd.last || !out_valid_reg || m_ready);
    assign cmd_ready = exec;
    assign m_valid   = out_valid_reg;
    assign m_status  = status_reg;
    assign stat.exec      = exec;
    assign stat.exec_last = exec && cmd.last;

    // Stack operation and status
    always_comb begin
        depth_next  = depth_reg;
        err_next    = err_reg;
        top_next    = top_reg;
        push_en     = 1'b0;
        status_next = ST_OK;
        if (exec) begin
            if (err_reg == ST_OK) begin
                case (cmd.kind)
                    OP_PUSH: begin
                        if (depth_reg == FULL_CNT) begin
                            err_next = ST_OVERFLOW;
                        end else begin
                            push_en    = 1'b1;
                            top_next   = cmd.code;
                            depth_next = depth_reg + 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (depth_reg == '0) begin
                            err_next = ST_MISMATCH;
                        end else begin
                            depth_next = depth_reg - 1'b1;
                            top_next   = under_reg;
                            if (top_reg != cmd.code) begin
                                err_next = ST_MISMATCH;
                            end
                        end
                    end
                    default: begin
                        depth_next = depth_reg;
                    end
                endcase
            end
            if (cmd.last) begin
                if (err_next != ST_OK) begin
                    status_next = err_next;
                end else if (depth_next != '0) begin
                    status_next = ST_OPEN;
                end else begin
                    status_next = ST_OK;
                end
                depth_next = '0;
                err_next   = ST_OK;
            end
        end
    end

    // Prefetch the entry just below the new top
    assign rd_cnt  = depth_next - TWO_CNT;
    assign rd_addr = rd_cnt[ADDR_W-1:0];
    assign wr_addr = depth_reg[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            depth_reg <= depth_next;
            err_reg   <= err_next;
            if (exec && cmd.last) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (exec && cmd.last) begin
            status_reg <= status_next;
        end
    end

    // Stack memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[wr_addr] <= cmd.code;
        end
        under_reg <= stack_mem[rd_addr];
    end

endmodule
